/* hdl/perlin_noise_2d_unit_macros.svh */
// Assertion macros for the 2D Perlin noise unit.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef PERLIN_NOISE_2D_UNIT_MACROS_SVH
`define PERLIN_NOISE_2D_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PN2D_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pn2d check failed");

// Next-cycle implication, disabled while in reset
`define PN2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pn2d check failed");

`endif

/* hdl/pn2d_pkg.sv */
// Package for the 2D Perlin noise unit: payload types, hash constants and
// the quarter-wave gradient tables. No dependencies.
`default_nettype none

package pn2d_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned INT_BITS_DEF  = 16;
  localparam int unsigned ANGLE_BITS    = 10;
  localparam int unsigned QSHIFT        = ANGLE_BITS - 2;
  localparam int unsigned QTR_N         = 1 << QSHIFT;

  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [7:0]  SHADE_OFFSET = 8'd127;

  typedef struct packed {
    logic [31:0] x_coord;
    logic [31:0] y_coord;
  } pn2d_in_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic [7:0]         shade;
  } pn2d_out_t;

  typedef logic [QTR_N-1:0][14:0] pn2d_lut_t;

  // sin over the quarter turn, Q30 in and out, Taylor series
  function automatic logic [63:0] sin_q30(logic [63:0] p);
    logic [63:0] p2;
    logic [63:0] term;
    logic [63:0] sum;
    p2   = (p * p) >> 30;
    term = p;
    sum  = p;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * p2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Q1.14 table, rounded half up; cos_sel picks sin(pi/2 - phi)
  function automatic pn2d_lut_t build_lut(logic cos_sel);
    pn2d_lut_t   lut;
    logic [63:0] phi;
    logic [63:0] v;
    for (int r = 0; r < QTR_N; r++) begin
      phi = (64'(r) * HALF_PI_Q30) >> QSHIFT;
      v   = cos_sel ? sin_q30(HALF_PI_Q30 - phi) : sin_q30(phi);
      lut[r] = 15'((v + 64'd32768) >> 16);
    end
    return lut;
  endfunction

  localparam pn2d_lut_t SIN_LUT = build_lut(1'b0);
  localparam pn2d_lut_t COS_LUT = build_lut(1'b1);

endpackage

`default_nettype wire

/* hdl/pn2d_hash.sv */
// Three-stage corner hash: multiply / xor / rotate by 16, top angle bits out.
// Depends on pn2d_pkg for the hash constants and ANGLE_BITS.
`default_nettype none

module pn2d_hash
  import pn2d_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [2:0]            ld_i,
  input  wire logic [31:0]           ix_i,
  input  wire logic [31:0]           iy_i,
  output logic      [ANGLE_BITS-1:0] angle_o
);

  logic [31:0] a1_q, iy1_q, a2_q, b2_q, h3_q;
  logic [31:0] b_mix, a_mix;

  assign b_mix = iy1_q ^ {a1_q[15:0], a1_q[31:16]};
  assign a_mix = a2_q ^ {b2_q[15:0], b2_q[31:16]};

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      a1_q  <= 32'(ix_i * HASH_K1);
      iy1_q <= iy_i;
    end
    if (ld_i[1]) begin
      a2_q <= a1_q;
      b2_q <= 32'(b_mix * HASH_K2);
    end
    if (ld_i[2]) begin
      h3_q <= 32'(a_mix * HASH_K3);
    end
  end

  assign angle_o = h3_q[31 -: ANGLE_BITS];

endmodule

`default_nettype wire

/* hdl/perlin_noise_2d_unit.sv */
// 2D Perlin gradient noise unit, nine-stage pipeline: one point per cycle
// in, one noise value and grey shade per point out. Throughput is one item
// per clock while the output is not stalled, set by the per-stage handshake;
// a stall holds the occupied run at the output while the stages behind it fill.
// Each of the three hash multiplies, the dot products and both blends take
// a stage of their own. Depends on pn2d_pkg, pn2d_hash and the macro header.
`default_nettype none

`include "perlin_noise_2d_unit_macros.svh"

module perlin_noise_2d_unit
  import pn2d_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned INT_BITS  = INT_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pn2d_in_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pn2d_out_t      out_rsp_o
);

  localparam int unsigned NST   = 9;
  localparam int unsigned DOT_W = 19;

  logic [NST-1:0] vld_q, adv, ld;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    ld[0] = adv[0] && in_valid_i;
    for (int k = 1; k < NST; k++) begin
      ld[k] = adv[k] && vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];

  // fractions travel alongside the request
  logic [FRAC_BITS-1:0] fx_q [0:NST-3];
  logic [FRAC_BITS-1:0] fy_q [0:NST-3];
  logic [INT_BITS-1:0]  x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x0_q     <= INT_BITS'(in_req_i.x_coord >> FRAC_BITS);
      y0_q     <= INT_BITS'(in_req_i.y_coord >> FRAC_BITS);
      fx_q[0]  <= in_req_i.x_coord[FRAC_BITS-1:0];
      fy_q[0]  <= in_req_i.y_coord[FRAC_BITS-1:0];
    end
    for (int k = 1; k < NST - 2; k++) begin
      if (ld[k]) begin
        fx_q[k] <= fx_q[k-1];
        fy_q[k] <= fy_q[k-1];
      end
    end
  end

  // corner c: bit 0 selects x0+1, bit 1 selects y0+1
  logic [ANGLE_BITS-1:0]   angle   [4];
  logic signed [15:0]      gs_q    [4];
  logic signed [15:0]      gc_q    [4];
  logic signed [DOT_W-1:0] dot_q   [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    logic [31:0]            ix, iy;
    logic [QSHIFT-1:0]      r;
    logic signed [15:0]     s, co, gs_d, gc_d;
    logic signed [FRAC_BITS:0]    dx, dy;
    logic signed [FRAC_BITS+17:0] dsum;

    assign ix = 32'(x0_q) + ((c % 2) == 1 ? 32'd1 : 32'd0);
    assign iy = 32'(y0_q) + ((c / 2) == 1 ? 32'd1 : 32'd0);

    pn2d_hash u_hash (
      .clk_i   (clk_i),
      .ld_i    (ld[3:1]),
      .ix_i    (ix),
      .iy_i    (iy),
      .angle_o (angle[c])
    );

    assign r  = angle[c][QSHIFT-1:0];
    assign s  = signed'({1'b0, SIN_LUT[r]});
    assign co = signed'({1'b0, COS_LUT[r]});

    always_comb begin
      case (angle[c][ANGLE_BITS-1 -: 2])
        2'd0:    begin gs_d = s;   gc_d = co;  end
        2'd1:    begin gs_d = co;  gc_d = -s;  end
        2'd2:    begin gs_d = -s;  gc_d = -co; end
        default: begin gs_d = -co; gc_d = s;   end
      endcase
    end

    // offset to the upper corner is frac - 1, i.e. the fraction with a set sign bit
    assign dx   = signed'({((c % 2) == 1) ? 1'b1 : 1'b0, fx_q[4]});
    assign dy   = signed'({((c / 2) == 1) ? 1'b1 : 1'b0, fy_q[4]});
    assign dsum = (FRAC_BITS+18)'(dx * gs_q[c]) + (FRAC_BITS+18)'(dy * gc_q[c]);

    always_ff @(posedge clk_i) begin
      if (ld[4]) begin
        gs_q[c] <= gs_d;
        gc_q[c] <= gc_d;
      end
      if (ld[5]) begin
        dot_q[c] <= dsum[FRAC_BITS+17 : FRAC_BITS-1];
      end
    end
  end

  // a + floor((b - a) * w / 2^FRAC_BITS); result stays between a and b
  function automatic logic signed [DOT_W-1:0] blend(logic signed [DOT_W-1:0] a,
                                                   logic signed [DOT_W-1:0] b,
                                                   logic [FRAC_BITS-1:0] w);
    logic signed [DOT_W:0]           diff;
    logic signed [DOT_W+FRAC_BITS+1:0] prod;
    logic signed [DOT_W+1:0]         sum;
    diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
    prod = (DOT_W+FRAC_BITS+2)'(diff * signed'({1'b0, w}));
    sum  = (DOT_W+2)'(a) + prod[DOT_W+FRAC_BITS+1 : FRAC_BITS];
    return sum[DOT_W-1:0];
  endfunction

  logic signed [DOT_W-1:0] row0_q, row1_q, v_q;
  logic signed [15:0]      sat;
  logic signed [16:0]      tsum;
  pn2d_out_t               rsp_d, rsp_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      row0_q <= blend(dot_q[0], dot_q[1], fx_q[5]);
      row1_q <= blend(dot_q[2], dot_q[3], fx_q[5]);
    end
    if (ld[7]) begin
      v_q <= blend(row0_q, row1_q, fy_q[6]);
    end
    if (ld[8]) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    if (v_q > DOT_W'(32767)) begin
      sat = 16'sd32767;
    end else if (v_q < -DOT_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = v_q[15:0];
    end
    // divide by 256 truncating toward zero
    tsum = 17'(sat) + (sat[15] ? 17'sd255 : 17'sd0);
    rsp_d.noise_value = sat;
    rsp_d.shade       = tsum[15:8] + SHADE_OFFSET;
  end

  assign out_rsp_o = rsp_q;

  `PN2D_ASSERT_IMPL(a_ready_when_drained, !vld_q[NST-1], in_ready_o)
  `PN2D_ASSERT_NEXT(a_accept_fills_first, in_valid_i && in_ready_o, vld_q[0])
  `PN2D_ASSERT_NEXT(a_hash_stage_holds, vld_q[3] && !adv[3], vld_q[3] && vld_q[4])

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for perlin_noise_2d_unit: drives random and edge-case points,
// predicts noise and shade per request, checks results in order.
// Depends on pn2d_pkg and the perlin_noise_2d_unit RTL.

module testbench;
  import pn2d_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned IB = INT_BITS_DEF;
  localparam int unsigned NUM_RANDOM = 1400;
  localparam int unsigned LATENCY = 9;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  pn2d_in_t  in_req_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  pn2d_out_t out_rsp_o;

  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit sink_hold = 1'b0;
  bit no_idle = 1'b0;

  perlin_noise_2d_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Q30 sine over the quarter turn
  function automatic longint unsigned taylor_sin(longint unsigned p);
    longint unsigned p2, term, acc;
    p2 = (p * p) >> 30;
    term = p;
    acc = p;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * p2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = (acc >= term) ? acc - term : 0;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [31:0] rot16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] hash_corner(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] a, b;
    a = ix * HASH_K1;
    b = iy ^ rot16(a);
    b = b * HASH_K2;
    a = a ^ rot16(b);
    return a * HASH_K3;
  endfunction

  function automatic longint floor_shr(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                        longint dx, longint dy);
    logic [31:0] k;
    logic [1:0] quad;
    longint unsigned r, phi;
    longint s, c, gs, gc;
    k = hash_corner(cx, cy) >> (32 - ANGLE_BITS);
    quad = k[ANGLE_BITS-1 -: 2];
    r = k & ((1 << (ANGLE_BITS - 2)) - 1);
    phi = (r * HALF_PI_Q30) >> (ANGLE_BITS - 2);
    s = longint'((taylor_sin(phi) + 32768) >> 16);
    c = longint'((taylor_sin(HALF_PI_Q30 - phi) + 32768) >> 16);
    case (quad)
      2'd0: begin gs = s; gc = c; end
      2'd1: begin gs = c; gc = -s; end
      2'd2: begin gs = -s; gc = -c; end
      default: begin gs = -c; gc = s; end
    endcase
    return floor_shr(dx * gs + dy * gc, FB - 1);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + floor_shr((b - a) * w, FB);
  endfunction

  function automatic pn2d_out_t predict_noise(pn2d_in_t req);
    logic [31:0] x0, y0;
    longint fx, fy, one, r0, r1, v, t;
    pn2d_out_t res;
    x0 = (req.x_coord >> FB) & ((32'd1 << IB) - 1);
    y0 = (req.y_coord >> FB) & ((32'd1 << IB) - 1);
    one = longint'(1) << FB;
    fx = longint'(req.x_coord & ((32'd1 << FB) - 1));
    fy = longint'(req.y_coord & ((32'd1 << FB) - 1));
    r0 = blend(corner_dot(x0, y0, fx, fy), corner_dot(x0 + 1, y0, fx - one, fy), fx);
    r1 = blend(corner_dot(x0, y0 + 1, fx, fy - one),
               corner_dot(x0 + 1, y0 + 1, fx - one, fy - one), fx);
    v = blend(r0, r1, fy);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    t = (v >= 0) ? (v >> 8) : -((-v) >> 8);
    res.noise_value = 16'(v);
    res.shade = 8'(t + longint'(SHADE_OFFSET));
    return res;
  endfunction

  class noise_scoreboard;
    pn2d_out_t pending[$];

    function void note_request(pn2d_in_t req);
      pending.push_back(predict_noise(req));
    endfunction

    task check_result(pn2d_out_t got);
      pn2d_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.noise_value !== want.noise_value)
        report_mismatch($sformatf("noise_value got %0d want %0d",
                                  got.noise_value, want.noise_value));
      if (got.shade !== want.shade)
        report_mismatch($sformatf("shade got %0d want %0d", got.shade, want.shade));
    endtask
  endclass

  noise_scoreboard sb = new();

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample on the edge, then update ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
      out_ready_i <= !sink_hold && (no_idle || $urandom_range(99) >= 21);
    end
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{x_coord: x, y_coord: y};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {16'($urandom_range(3)), 16'($urandom)};
      2: return {16'hFFFF - 16'($urandom_range(2)), 16'($urandom)};
      3: return {16'($urandom), 16'($urandom_range(1)) ? 16'hFFFF : 16'h0000};
      default: return {16'($urandom_range(40)), 16'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
              32'h0001_8000, 32'h8000_0001};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edges[i]) send_point(edges[i], edges[(i + 2) % 6]);
    for (int i = 0; i < 12; i++) send_point(32'h5555_AAAA ^ (i << 14), 32'hAAAA_5555 + i);
    drain();

    // long receiver hold while the sender keeps offering
    fork
      begin
        sink_hold = 1'b1;
        repeat (60) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord());
    join
    drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_idle = (i >= 500 && i < 700);
      send_point(rand_coord(), rand_coord());
    end
    no_idle = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/pn2d_pkg.sv
hdl/pn2d_hash.sv
hdl/perlin_noise_2d_unit.sv
sim/testbench.sv
